### hw/rtl/mi_pkg.sv
// Shared types, constants and microcode program for the modular inverse unit.
// Used by mi_datapath and modular_inverse_unit; depends on nothing else.
package mi_pkg;

	localparam int WIDTH = 31;
	localparam int CW    = WIDTH + 2;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int PC_W  = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DINIT,
		OP_DSTEP,
		OP_UPD,
		OP_FIX,
		OP_EMIT_OK,
		OP_EMIT_FAIL,
		OP_EMIT_ZERO
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOSTART,
		C_MOD_ZERO,
		C_MOD_ONE,
		C_RB_ZERO,
		C_RB_ONE,
		C_CNT_NZ
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctrl_t;

	typedef struct packed {
		logic mod_zero;
		logic mod_one;
		logic rb_zero;
		logic rb_one;
		logic cnt_nz;
	} flags_t;

	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_CHK0  = 4'd1;
	localparam logic [PC_W-1:0] PC_CHK1  = 4'd2;
	localparam logic [PC_W-1:0] PC_LOOP  = 4'd3;
	localparam logic [PC_W-1:0] PC_TST1  = 4'd4;
	localparam logic [PC_W-1:0] PC_DINIT = 4'd5;
	localparam logic [PC_W-1:0] PC_DSTEP = 4'd6;
	localparam logic [PC_W-1:0] PC_UPD   = 4'd7;
	localparam logic [PC_W-1:0] PC_FIX   = 4'd8;
	localparam logic [PC_W-1:0] PC_OK    = 4'd9;
	localparam logic [PC_W-1:0] PC_FAIL  = 4'd10;
	localparam logic [PC_W-1:0] PC_ZERO  = 4'd11;

	// control store: a jump is taken when cond holds, otherwise advance
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = '{op: OP_NOP, cond: C_ALWAYS, target: PC_WAIT};
		case (pc)
			PC_WAIT:  cw = '{op: OP_LOAD,      cond: C_NOSTART,  target: PC_WAIT};
			PC_CHK0:  cw = '{op: OP_NOP,       cond: C_MOD_ZERO, target: PC_FAIL};
			PC_CHK1:  cw = '{op: OP_NOP,       cond: C_MOD_ONE,  target: PC_ZERO};
			PC_LOOP:  cw = '{op: OP_NOP,       cond: C_RB_ZERO,  target: PC_FAIL};
			PC_TST1:  cw = '{op: OP_NOP,       cond: C_RB_ONE,   target: PC_FIX};
			PC_DINIT: cw = '{op: OP_DINIT,     cond: C_NEVER,    target: PC_WAIT};
			PC_DSTEP: cw = '{op: OP_DSTEP,     cond: C_CNT_NZ,   target: PC_DSTEP};
			PC_UPD:   cw = '{op: OP_UPD,       cond: C_ALWAYS,   target: PC_LOOP};
			PC_FIX:   cw = '{op: OP_FIX,       cond: C_NEVER,    target: PC_WAIT};
			PC_OK:    cw = '{op: OP_EMIT_OK,   cond: C_ALWAYS,   target: PC_WAIT};
			PC_FAIL:  cw = '{op: OP_EMIT_FAIL, cond: C_ALWAYS,   target: PC_WAIT};
			PC_ZERO:  cw = '{op: OP_EMIT_ZERO, cond: C_ALWAYS,   target: PC_WAIT};
			default:  cw = '{op: OP_NOP,       cond: C_ALWAYS,   target: PC_WAIT};
		endcase
		return cw;
	endfunction

endpackage

### hw/rtl/mi_datapath.sv
// Datapath of the modular inverse unit: remainder and coefficient pairs,
// bit-serial restoring divider and quotient-times-coefficient accumulator.
// Depends on mi_pkg; driven one control word per cycle by the sequencer.
module mi_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mi_pkg::op_t               op,
	input  logic [mi_pkg::WIDTH-1:0]  value,
	input  logic [mi_pkg::WIDTH-1:0]  modulus,
	output mi_pkg::flags_t            flags,
	output logic [mi_pkg::WIDTH-1:0]  coef
);

	logic [mi_pkg::WIDTH-1:0] ra_q, rb_q, mod_q, rem_q, dvd_q;
	logic signed [mi_pkg::CW-1:0] ca_q, cb_q, acc_q;
	logic [mi_pkg::CNT_W-1:0] cnt_q;

	logic [mi_pkg::WIDTH:0] trial;
	logic [mi_pkg::WIDTH:0] diff;
	logic                   qbit;

	assign trial = {rem_q, dvd_q[mi_pkg::WIDTH-1]};
	assign diff  = trial - {1'b0, rb_q};
	assign qbit  = !diff[mi_pkg::WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (op)
				mi_pkg::OP_DINIT: cnt_q <= mi_pkg::CNT_W'(mi_pkg::WIDTH - 1);
				mi_pkg::OP_DSTEP: cnt_q <= cnt_q - 1'b1;
				default:          cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			mi_pkg::OP_LOAD: begin
				ra_q  <= modulus;
				rb_q  <= value;
				mod_q <= modulus;
				ca_q  <= '0;
				cb_q  <= mi_pkg::CW'(1);
			end
			mi_pkg::OP_DINIT: begin
				rem_q <= '0;
				dvd_q <= ra_q;
				acc_q <= '0;
			end
			mi_pkg::OP_DSTEP: begin
				rem_q <= qbit ? diff[mi_pkg::WIDTH-1:0] : trial[mi_pkg::WIDTH-1:0];
				dvd_q <= {dvd_q[mi_pkg::WIDTH-2:0], 1'b0};
				acc_q <= (acc_q <<< 1) + (qbit ? cb_q : '0);
			end
			mi_pkg::OP_UPD: begin
				ra_q <= rb_q;
				rb_q <= rem_q;
				ca_q <= cb_q;
				cb_q <= ca_q - acc_q;
			end
			mi_pkg::OP_FIX: begin
				if (cb_q[mi_pkg::CW-1]) begin
					cb_q <= cb_q + $signed({2'b00, mod_q});
				end
			end
			default: begin
			end
		endcase
	end

	assign flags.mod_zero = (mod_q == '0);
	assign flags.mod_one  = (mod_q == mi_pkg::WIDTH'(1));
	assign flags.rb_zero  = (rb_q == '0);
	assign flags.rb_one   = (rb_q == mi_pkg::WIDTH'(1));
	assign flags.cnt_nz   = (cnt_q != '0);
	assign coef           = cb_q[mi_pkg::WIDTH-1:0];

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		op == mi_pkg::OP_DSTEP |=> rem_q < rb_q)
		else $error("remainder not below divisor");
	a_ra_order: assert property (@(posedge clk) disable iff (!arst_n)
		op == mi_pkg::OP_UPD |=> rb_q < ra_q)
		else $error("remainder pair out of order");
	a_fix_pos: assert property (@(posedge clk) disable iff (!arst_n)
		op == mi_pkg::OP_FIX |=> !cb_q[mi_pkg::CW-1])
		else $error("coefficient still negative");

endmodule

### hw/rtl/modular_inverse_unit.sv
// Top level of the modular inverse unit: microcoded sequencer, output registers.
// Depends on mi_pkg and mi_datapath.
//
// Usage: drive value and modulus and raise start while busy is low; the
// request is taken at that edge and busy rises on the next cycle. When the
// work ends, done is high for exactly one cycle with inverse and status;
// status 1 means gcd(value, modulus) is not one and inverse is then zero.
// A modulus of one gives inverse 0, status 0; a modulus of zero status 1.
// Results are not held: the receiver must take them in the done cycle.
// The sequencer runs 2 modulus check steps, then one Euclid iteration per
// quotient, each WIDTH + 4 steps (two remainder tests, divider setup, WIDTH
// steps of bit-serial restoring divide with one quotient bit per cycle,
// update), then 2 to 4 steps to finish; done comes from the output
// register. There are at most 44 quotients for 31-bit operands. The
// divider loop sets the rate. One request is worked at a time; a new one
// may be taken in the cycle done is shown. Reset returns the sequencer to
// the wait step and clears done; nothing is kept between requests.
module modular_inverse_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mi_pkg::WIDTH-1:0]  value,
	input  logic [mi_pkg::WIDTH-1:0]  modulus,
	output logic                      busy,
	output logic                      done,
	output logic [mi_pkg::WIDTH-1:0]  inverse,
	output logic                      status
);

	logic [mi_pkg::PC_W-1:0]  pc_q;
	logic [mi_pkg::PC_W-1:0]  pc_next;
	mi_pkg::ctrl_t            cw;
	mi_pkg::flags_t           flags;
	logic                     taken;
	logic [mi_pkg::WIDTH-1:0] coef;
	logic                     done_q;
	logic                     status_q;
	logic [mi_pkg::WIDTH-1:0] inverse_q;

	assign cw = mi_pkg::ucode(pc_q);

	mi_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (cw.op),
		.value   (value),
		.modulus (modulus),
		.flags   (flags),
		.coef    (coef)
	);

	always_comb begin
		case (cw.cond)
			mi_pkg::C_NEVER:    taken = 1'b0;
			mi_pkg::C_ALWAYS:   taken = 1'b1;
			mi_pkg::C_NOSTART:  taken = !start;
			mi_pkg::C_MOD_ZERO: taken = flags.mod_zero;
			mi_pkg::C_MOD_ONE:  taken = flags.mod_one;
			mi_pkg::C_RB_ZERO:  taken = flags.rb_zero;
			mi_pkg::C_RB_ONE:   taken = flags.rb_one;
			mi_pkg::C_CNT_NZ:   taken = flags.cnt_nz;
			default:            taken = 1'b1;
		endcase
		pc_next = taken ? cw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= mi_pkg::PC_WAIT;
			done_q    <= 1'b0;
			status_q  <= 1'b0;
			inverse_q <= '0;
		end else begin
			pc_q   <= pc_next;
			done_q <= 1'b0;
			case (cw.op)
				mi_pkg::OP_EMIT_OK: begin
					done_q    <= 1'b1;
					status_q  <= 1'b0;
					inverse_q <= coef;
				end
				mi_pkg::OP_EMIT_FAIL: begin
					done_q    <= 1'b1;
					status_q  <= 1'b1;
					inverse_q <= '0;
				end
				mi_pkg::OP_EMIT_ZERO: begin
					done_q    <= 1'b1;
					status_q  <= 1'b0;
					inverse_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy    = (pc_q != mi_pkg::PC_WAIT);
	assign done    = done_q;
	assign status  = status_q;
	assign inverse = inverse_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> inverse == '0)
		else $error("failed request with nonzero inverse");
	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without going busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

endmodule

### verif/modular_inverse_unit_tb.sv
// Testbench for modular_inverse_unit: directed table then random requests,
// each result checked against the table entry, if given, or an extended
// Euclid predictor in this file. Depends on mi_pkg and the unit's RTL.
`timescale 1ns / 1ps

module modular_inverse_unit_tb;

	localparam int W               = mi_pkg::WIDTH;
	localparam int RANDOM_REQUESTS = 350;
	localparam int STALL_LIMIT     = 20000;
	localparam int DRAIN_CYCLES    = 2000;

	localparam logic           ST_FOUND = 1'b0;
	localparam logic           ST_NONE  = 1'b1;
	localparam logic [W-1:0]   TOP      = '1;

	typedef struct packed {
		logic [W-1:0] inverse;
		logic         status;
	} inv_result_t;

	typedef struct packed {
		logic [W-1:0] value;
		logic [W-1:0] modulus;
		logic         given;
		inv_result_t  result;
	} request_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic [W-1:0]  value;
	logic [W-1:0]  modulus;
	logic          busy;
	logic          done;
	logic [W-1:0]  inverse;
	logic          status;

	logic          req_given;
	inv_result_t   req_result;
	bit            gaps_on;

	inv_result_t   expected_results[$];
	int            errors;
	int            stall_cycles;
	request_row_t  directed_rows [0:21];

	modular_inverse_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.modulus (modulus),
		.busy    (busy),
		.done    (done),
		.inverse (inverse),
		.status  (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic inv_result_t compute_inverse(input logic [W-1:0] v,
			input logic [W-1:0] m);
		longint ra, rb, ca, cb, q, rt, ct;
		inv_result_t r;
		r.inverse = '0;
		r.status  = ST_NONE;
		if (m == 1) begin
			r.status = ST_FOUND;
			return r;
		end
		if (m == 0)
			return r;
		ra = longint'(m);
		rb = longint'(v);
		ca = 0;
		cb = 1;
		while (rb != 0 && rb != 1) begin
			q  = ra / rb;
			rt = ra - q * rb;
			ct = ca - q * cb;
			ra = rb;
			ca = cb;
			rb = rt;
			cb = ct;
		end
		if (rb == 1) begin
			if (cb < 0)
				cb = cb + longint'(m);
			r.inverse = cb[W-1:0];
			r.status  = ST_FOUND;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		errors++;
		$display("mismatch at %0d ns: %s expected %0d got %0d", $time, what, want, got);
	endtask

	// hold the request until start meets a low busy at a clock edge
	task automatic send_request(input logic [W-1:0] v, input logic [W-1:0] m,
			input logic given, input inv_result_t res);
		int gap;
		if (gaps_on && $urandom_range(0, 99) < 36) begin
			gap = $urandom_range(1, 40);
			start   <= 1'b0;
			value   <= W'($urandom);
			modulus <= W'($urandom);
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		value      <= v;
		modulus    <= m;
		req_given  <= given;
		req_result <= res;
		do @(posedge clk); while (!(start && !busy));
	endtask

	always @(posedge clk) begin : monitor_results
		inv_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding, inverse", 0, inverse);
				end else begin
					want = expected_results.pop_front();
					if (inverse !== want.inverse)
						report_mismatch("inverse", want.inverse, inverse);
					if (status !== want.status)
						report_mismatch("status", want.status, status);
				end
			end
			if (start && !busy)
				expected_results.push_back(req_given ? req_result : compute_inverse(value, modulus));
			if (done || (start && !busy))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic [W-1:0] v, m;
		int unsigned f, lim;
		arst_n       = 1'b0;
		start        = 1'b0;
		value        = '0;
		modulus      = '0;
		req_given    = 1'b0;
		req_result   = '0;
		gaps_on      = 1'b1;
		errors       = 0;
		stall_cycles = 0;
		directed_rows = '{
			'{31'd5,          31'd0,          1'b1, '{31'd0, ST_NONE}},
			'{31'd0,          31'd0,          1'b1, '{31'd0, ST_NONE}},
			'{31'd7,          31'd1,          1'b1, '{31'd0, ST_FOUND}},
			'{TOP,            31'd1,          1'b1, '{31'd0, ST_FOUND}},
			'{31'd0,          31'd13,         1'b1, '{31'd0, ST_NONE}},
			'{31'd0,          TOP,            1'b1, '{31'd0, ST_NONE}},
			'{31'd1,          31'd2,          1'b1, '{31'd1, ST_FOUND}},
			'{31'd1,          TOP,            1'b1, '{31'd1, ST_FOUND}},
			'{TOP - 31'd1,    TOP,            1'b1, '{TOP - 31'd1, ST_FOUND}},
			'{TOP,            TOP,            1'b1, '{31'd0, ST_NONE}},
			'{31'd6,          31'd9,          1'b1, '{31'd0, ST_NONE}},
			'{31'd3,          31'd7,          1'b1, '{31'd5, ST_FOUND}},
			'{31'd10,         31'd7,          1'b1, '{31'd5, ST_FOUND}},
			'{TOP,            31'd2,          1'b1, '{31'd1, ST_FOUND}},
			'{31'd12,         31'd18,         1'b1, '{31'd0, ST_NONE}},
			'{31'd4,          31'd2,          1'b1, '{31'd0, ST_NONE}},
			'{31'd2,          TOP,            1'b0, '{31'd0, ST_FOUND}},
			'{31'd1134903170, 31'd1836311903, 1'b0, '{31'd0, ST_FOUND}},
			'{31'd1836311903, 31'd1134903170, 1'b0, '{31'd0, ST_FOUND}},
			'{TOP,            TOP - 31'd1,    1'b0, '{31'd0, ST_FOUND}},
			'{31'h40000000,   TOP,            1'b0, '{31'd0, ST_FOUND}},
			'{31'h2aaaaaaa,   31'h55555555,   1'b0, '{31'd0, ST_FOUND}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].value, directed_rows[i].modulus,
				directed_rows[i].given, directed_rows[i].result);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			gaps_on = !(n >= 120 && n < 200);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: begin
					v = W'($urandom);
					m = W'($urandom);
				end
				7, 8, 9, 10: begin
					m = W'($urandom_range(2, 1000));
					v = W'($urandom_range(0, 2000));
				end
				11, 12, 13: begin
					f   = $urandom_range(2, 1000);
					lim = 32'h7fffffff / f;
					v   = W'(f * $urandom_range(1, lim));
					m   = W'(f * $urandom_range(1, lim));
				end
				14, 15: begin
					m = TOP;
					v = W'($urandom);
				end
				16, 17: begin
					m = W'($urandom_range(2, 32'h00ffffff));
					v = W'($urandom) | 31'h40000000;
				end
				18: begin
					case ($urandom_range(0, 2))
						0: begin v = W'($urandom); m = '0; end
						1: begin v = W'($urandom); m = 31'd1; end
						default: begin v = '0; m = W'($urandom); end
					endcase
				end
				default: begin
					v = TOP - W'($urandom_range(0, 15));
					m = TOP - W'($urandom_range(0, 15));
				end
			endcase
			send_request(v, m, 1'b0, '0);
		end
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/mi_pkg.sv
hw/rtl/mi_datapath.sv
hw/rtl/modular_inverse_unit.sv
verif/modular_inverse_unit_tb.sv
